// ===== src/blac_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// blac_pkg: shared types and codes of the buffer lifetime alias checker
// Result kinds, verdict codes, register indexes and field widths.
// ----------------------------------------------------------------------------
package blac_pkg;

  localparam int unsigned CapW   = 34;
  localparam int unsigned AlignW = 32;
  localparam int unsigned DataW  = 32;
  localparam int unsigned StepW  = 20;
  localparam int unsigned EndW   = 33;
  localparam int unsigned RowW   = 10;
  localparam int unsigned CfgW   = 34;

  localparam logic [0:0] RegPoolCapacity = 1'b0;
  localparam logic [0:0] RegAlignBytes   = 1'b1;

  localparam logic [1:0] KindRow     = 2'd0;
  localparam logic [1:0] KindPair    = 2'd1;
  localparam logic [1:0] KindSummary = 2'd2;

  localparam logic [1:0] VerdictPass     = 2'd0;
  localparam logic [1:0] VerdictFail     = 2'd1;
  localparam logic [1:0] VerdictOverflow = 2'd2;

  localparam logic [AlignW-1:0] AlignReset = 32'd128;

  // Control between the sequencer and the remainder unit.
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } mod_ctl_t;

endpackage
`default_nettype wire

// ===== src/blac_mod_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// blac_mod_unit: serial remainder of offset by alignment
// Restoring division, one quotient bit per cycle; a start is taken only while idle.
// ----------------------------------------------------------------------------
module blac_mod_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [blac_pkg::DataW-1:0]  dividend_i,
  input  wire logic [blac_pkg::AlignW-1:0] divisor_i,
  output logic                             busy_o,
  output logic                             done_o,
  output logic                             nonzero_o
);
  import blac_pkg::*;

  logic [DataW-1:0]  num_q, num_d;
  logic [AlignW:0]   rem_q, rem_d;
  logic [AlignW-1:0] div_q, div_d;
  logic [5:0]        cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;
  logic [AlignW:0]   trial;

  // Start load, or one shift-subtract step while busy.
  always_comb begin
    trial  = {rem_q[AlignW-1:0], num_q[DataW-1]};
    num_d  = num_q;
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i && !busy_q) begin
      num_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
      cnt_d  = 6'(DataW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[DataW-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) rem_d = trial - {1'b0, div_q};
      else rem_d = trial;
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign busy_o    = busy_q;
  assign done_o    = done_q;
  assign nonzero_o = (div_q != '0) && (rem_q != '0);

endmodule
`default_nettype wire

// ===== src/buffer_lifetime_alias_checker_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// buffer_lifetime_alias_checker_unit: buffer placement row and alias checker
// Checks each placement row, stores it while room remains, and scans stored pairs on the final row.
// ----------------------------------------------------------------------------
// Usage: rows arrive on the input channel (valid/stall). Each accepted row
// gives one row-check result once the serial remainder unit, one bit per
// cycle, finishes; the result is loaded as soon as the output register is
// free. The block takes no new row until the row's results are all loaded
// into the output register. On a final row the sequencer then walks the
// stored pairs i<j, one pair per memory read pair, until all are checked or
// MAX_REPORTS alias reports are made; each pair passes a read state and a
// check state, a reported pair also an output state. It emits each alias
// report and then a summary, flagged last. The row memory uses one write port
// and two read ports. Configuration writes take effect at once and are meant
// for idle times. Reset clears the sequencer's counters and flags and the
// output valid flag, not the output fields; the stored rows are undefined
// until written and need no clearing pass. When the receiver stalls, the
// pending result holds in the output register and the sequencer waits.
// ----------------------------------------------------------------------------
module buffer_lifetime_alias_checker_unit #(
  parameter int unsigned ROW_CAPACITY = 1024,
  parameter int unsigned MAX_REPORTS  = 51
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_index_i,
  input  wire logic [blac_pkg::CfgW-1:0]   cfg_data_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [blac_pkg::DataW-1:0]  buffer_id_i,
  input  wire logic [blac_pkg::DataW-1:0]  base_offset_i,
  input  wire logic [blac_pkg::DataW-1:0]  byte_size_i,
  input  wire logic [blac_pkg::StepW-1:0]  live_from_i,
  input  wire logic [blac_pkg::StepW-1:0]  live_until_i,
  input  wire logic                        final_row_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [1:0]                       result_kind_o,
  output logic [blac_pkg::RowW-1:0]        row_a_o,
  output logic [blac_pkg::RowW-1:0]        row_b_o,
  output logic [blac_pkg::DataW-1:0]       id_a_o,
  output logic [blac_pkg::DataW-1:0]       id_b_o,
  output logic                             out_of_bounds_o,
  output logic                             misaligned_o,
  output logic                             bad_lifetime_o,
  output logic [5:0]                       conflict_count_o,
  output logic [blac_pkg::EndW-1:0]        pool_used_o,
  output logic [1:0]                       verdict_o,
  output logic                             last_o
);
  import blac_pkg::*;

  localparam int unsigned AddrW = (ROW_CAPACITY > 1) ? $clog2(ROW_CAPACITY) : 1;
  localparam int unsigned CntW  = $clog2(ROW_CAPACITY + 1);
  localparam int unsigned RepW  = $clog2(MAX_REPORTS + 1);
  localparam int unsigned MemW  = 3 * DataW + 2 * StepW;

  typedef enum logic [2:0] {
    StIdle, StMod, StRowOut, StRead, StCheck, StPairOut, StSumOut
  } state_e;

  // Configuration registers.
  logic [CapW-1:0]   cap_q;
  logic [AlignW-1:0] align_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= '0;
      align_q <= AlignReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegPoolCapacity: cap_q   <= cfg_data_i[CapW-1:0];
        RegAlignBytes:   align_q <= cfg_data_i[AlignW-1:0];
        default: ;
      endcase
    end
  end

  // Row memory, one write and two registered reads.
  logic [MemW-1:0] mem [ROW_CAPACITY];
  logic [MemW-1:0] rd_a_q, rd_b_q;
  logic            we;
  logic [AddrW-1:0] wa, ra, rb;
  logic [MemW-1:0] wdata;

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wdata;
    rd_a_q <= mem[ra];
    rd_b_q <= mem[rb];
  end

  // Captured row.
  logic [DataW-1:0] id_q, off_q, size_q;
  logic [StepW-1:0] from_q, until_q;
  logic             final_q;
  logic [EndW-1:0]  end_row;
  assign end_row = {1'b0, off_q} + {1'b0, size_q};

  state_e          state_q;
  logic [CntW-1:0] count_q;
  logic            fail_q, ovf_q;
  logic [EndW-1:0] high_q;
  logic [CntW-1:0] i_q, j_q;
  logic [RepW-1:0] rep_q;
  logic            ov_q;
  logic [1:0]      kind_q;
  logic [RowW-1:0] ra_q, rb_q;
  logic [DataW-1:0] ia_q, ib_q;
  logic            oob_q, mis_q, bad_q, last_q;
  logic [5:0]      cc_q;
  logic [EndW-1:0] used_q;
  logic [1:0]      verd_q;

  logic mod_busy, mod_done, mod_nz, mod_start;
  assign mod_start = (state_q == StIdle) && in_valid_i;

  blac_mod_unit u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (base_offset_i),
    .divisor_i  (align_q),
    .busy_o     (mod_busy),
    .done_o     (mod_done),
    .nonzero_o  (mod_nz)
  );

  assign we    = (state_q == StMod) && mod_done && (count_q < CntW'(ROW_CAPACITY));
  assign wa    = count_q[AddrW-1:0];
  assign wdata = {id_q, off_q, size_q, from_q, until_q};
  assign ra    = i_q[AddrW-1:0];
  assign rb    = j_q[AddrW-1:0];

  // Pair test on the two read words.
  logic [DataW-1:0] oa, sa, ob, sb;
  logic [StepW-1:0] fa, ua, fb, ub;
  logic [DataW-1:0] ida, idb;
  logic [EndW-1:0]  ea, eb;
  logic             hit;
  always_comb begin
    {ida, oa, sa, fa, ua} = rd_a_q;
    {idb, ob, sb, fb, ub} = rd_b_q;
    ea  = {1'b0, oa} + {1'b0, sa};
    eb  = {1'b0, ob} + {1'b0, sb};
    hit = (fa < ub) && (fb < ua) && ({1'b0, oa} < eb) && ({1'b0, ob} < ea);
  end

  logic out_free;
  assign out_free = !ov_q || !out_stall_i;

  // A result is loaded into the output register in this cycle.
  logic load_out;
  assign load_out = out_free && (((state_q == StMod) && mod_done) ||
                                 (state_q == StRowOut) || (state_q == StPairOut) ||
                                 (state_q == StSumOut));

  // Next pair indexes after (i,j).
  logic [CntW-1:0] ni, nj;
  logic            scan_end;
  always_comb begin
    ni = i_q;
    nj = j_q + CntW'(1);
    if (nj >= count_q) begin
      ni = i_q + CntW'(1);
      nj = i_q + CntW'(2);
    end
    scan_end = (nj >= count_q);
  end

  // Sequencer and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      fail_q  <= 1'b0;
      ovf_q   <= 1'b0;
      high_q  <= '0;
      i_q     <= '0;
      j_q     <= '0;
      rep_q   <= '0;
      ov_q    <= 1'b0;
      final_q <= 1'b0;
    end else begin
      ov_q <= load_out || (ov_q && out_stall_i);
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            final_q <= final_row_i;
            state_q <= StMod;
          end
        end
        StMod: begin
          if (mod_done && out_free) begin
            kind_q <= KindRow;
            ra_q   <= count_q[RowW-1:0];
            rb_q   <= '0;
            ia_q   <= id_q;
            ib_q   <= '0;
            oob_q  <= (cap_q != '0) && ({1'b0, end_row} > cap_q);
            mis_q  <= mod_nz;
            bad_q  <= until_q <= from_q;
            cc_q   <= '0;
            used_q <= '0;
            verd_q <= VerdictPass;
            last_q <= !final_q;
            if (((cap_q != '0) && ({1'b0, end_row} > cap_q)) || mod_nz ||
                (until_q <= from_q)) fail_q <= 1'b1;
            if (end_row > high_q) high_q <= end_row;
            if (count_q < CntW'(ROW_CAPACITY)) count_q <= count_q + CntW'(1);
            else ovf_q <= 1'b1;
            i_q     <= '0;
            j_q     <= CntW'(1);
            rep_q   <= '0;
            state_q <= final_q ? StRead : StIdle;
          end else if (mod_done) begin
            state_q <= StRowOut;
          end
        end
        StRowOut: begin
          if (out_free) begin
            kind_q <= KindRow;
            ra_q   <= count_q[RowW-1:0];
            rb_q   <= '0;
            ia_q   <= id_q;
            ib_q   <= '0;
            oob_q  <= (cap_q != '0) && ({1'b0, end_row} > cap_q);
            mis_q  <= mod_nz;
            bad_q  <= until_q <= from_q;
            cc_q   <= '0;
            used_q <= '0;
            verd_q <= VerdictPass;
            last_q <= !final_q;
            if (((cap_q != '0) && ({1'b0, end_row} > cap_q)) || mod_nz ||
                (until_q <= from_q)) fail_q <= 1'b1;
            if (end_row > high_q) high_q <= end_row;
            if (count_q < CntW'(ROW_CAPACITY)) count_q <= count_q + CntW'(1);
            else ovf_q <= 1'b1;
            i_q     <= '0;
            j_q     <= CntW'(1);
            rep_q   <= '0;
            state_q <= final_q ? StRead : StIdle;
          end
        end
        StRead: begin
          if (j_q >= count_q) state_q <= StSumOut;
          else state_q <= StCheck;
        end
        StCheck: begin
          if (hit) begin
            state_q <= StPairOut;
          end else begin
            i_q     <= ni;
            j_q     <= nj;
            state_q <= scan_end ? StSumOut : StRead;
          end
        end
        StPairOut: begin
          if (out_free) begin
            kind_q <= KindPair;
            ra_q   <= i_q[RowW-1:0];
            rb_q   <= j_q[RowW-1:0];
            ia_q   <= ida;
            ib_q   <= idb;
            oob_q  <= 1'b0;
            mis_q  <= 1'b0;
            bad_q  <= 1'b0;
            cc_q   <= '0;
            used_q <= '0;
            verd_q <= VerdictPass;
            last_q <= 1'b0;
            fail_q <= 1'b1;
            rep_q  <= rep_q + RepW'(1);
            i_q    <= ni;
            j_q    <= nj;
            if (scan_end || (rep_q + RepW'(1) >= RepW'(MAX_REPORTS))) state_q <= StSumOut;
            else state_q <= StRead;
          end
        end
        StSumOut: begin
          if (out_free) begin
            kind_q <= KindSummary;
            ra_q   <= '0;
            rb_q   <= '0;
            ia_q   <= '0;
            ib_q   <= '0;
            oob_q  <= 1'b0;
            mis_q  <= 1'b0;
            bad_q  <= 1'b0;
            cc_q   <= 6'(rep_q);
            used_q <= high_q;
            verd_q <= ovf_q ? VerdictOverflow : (fail_q ? VerdictFail : VerdictPass);
            last_q <= 1'b1;
            count_q <= '0;
            fail_q  <= 1'b0;
            ovf_q   <= 1'b0;
            high_q  <= '0;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Row capture at transfer.
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i) begin
      id_q    <= buffer_id_i;
      off_q   <= base_offset_i;
      size_q  <= byte_size_i;
      from_q  <= live_from_i;
      until_q <= live_until_i;
    end
  end

  assign in_stall_o       = (state_q != StIdle);
  assign out_valid_o      = ov_q;
  assign result_kind_o    = kind_q;
  assign row_a_o          = ra_q;
  assign row_b_o          = rb_q;
  assign id_a_o           = ia_q;
  assign id_b_o           = ib_q;
  assign out_of_bounds_o  = oob_q;
  assign misaligned_o     = mis_q;
  assign bad_lifetime_o   = bad_q;
  assign conflict_count_o = cc_q;
  assign pool_used_o      = used_q;
  assign verdict_o        = verd_q;
  assign last_o           = last_q;

  // Checks on the sequencer.
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_busy |-> in_stall_o) else $error("remainder unit busy while ready");
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(ROW_CAPACITY)) else $error("row count past capacity");
  a_rep_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rep_q <= RepW'(MAX_REPORTS)) else $error("report count past limit");
  a_sum_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSumOut && out_free) |=> (count_q == '0 && state_q == StIdle))
    else $error("summary did not clear state");

endmodule
`default_nettype wire

// ===== tb/buffer_lifetime_alias_checker_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buffer_lifetime_alias_checker_unit_tb: self-checking bench for the checker
// Sends placement tables, predicts every row check, alias pair and summary in
// the bench, and compares each output transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module buffer_lifetime_alias_checker_unit_tb;
  import blac_pkg::*;

  localparam int unsigned RowCap     = 1024;
  localparam int unsigned ReportCap  = 51;
  localparam longint unsigned CycleLimit = 3000000;

  typedef struct packed {
    logic [1:0]        kind;
    logic [RowW-1:0]   ra;
    logic [RowW-1:0]   rb;
    logic [DataW-1:0]  ida;
    logic [DataW-1:0]  idb;
    logic              oob;
    logic              mis;
    logic              bad;
    logic [5:0]        cnt;
    logic [EndW-1:0]   used;
    logic [1:0]        verdict;
    logic              last;
  } alias_result_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_index_i;
  logic [CfgW-1:0] cfg_data_i;
  logic in_valid_i;
  logic in_stall_o;
  logic [DataW-1:0] buffer_id_i;
  logic [DataW-1:0] base_offset_i;
  logic [DataW-1:0] byte_size_i;
  logic [StepW-1:0] live_from_i;
  logic [StepW-1:0] live_until_i;
  logic final_row_i;
  logic out_valid_o;
  logic out_stall_i;
  logic [1:0] result_kind_o;
  logic [RowW-1:0] row_a_o;
  logic [RowW-1:0] row_b_o;
  logic [DataW-1:0] id_a_o;
  logic [DataW-1:0] id_b_o;
  logic out_of_bounds_o;
  logic misaligned_o;
  logic bad_lifetime_o;
  logic [5:0] conflict_count_o;
  logic [EndW-1:0] pool_used_o;
  logic [1:0] verdict_o;
  logic last_o;

  buffer_lifetime_alias_checker_unit DUT (.*);

  // Bench copy of the configuration and the table state.
  logic [CapW-1:0]   model_capacity;
  logic [AlignW-1:0] model_align;
  logic [DataW-1:0]  tbl_id [RowCap];
  logic [DataW-1:0]  tbl_off [RowCap];
  logic [DataW-1:0]  tbl_size [RowCap];
  logic [StepW-1:0]  tbl_from [RowCap];
  logic [StepW-1:0]  tbl_until [RowCap];
  int unsigned       tbl_rows;
  logic              tbl_failed;
  logic              tbl_overflow;
  logic [EndW-1:0]   tbl_highest;

  alias_result_t expected_results[$];
  int unsigned error_count;
  int unsigned rows_sent;
  int unsigned results_seen;
  int unsigned pairs_seen;
  int unsigned summaries_seen;
  bit          quiet;
  longint unsigned cycle_count = 0;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results pending", cycle_count,
               expected_results.size());
      $display("buffer_lifetime_alias_checker_unit_tb: FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= 40) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] exp);
    if (got !== exp) report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, exp));
  endtask

  // Predict all results caused by one accepted row.
  task automatic predict_alias_results(input logic [DataW-1:0] id, input logic [DataW-1:0] off,
                                       input logic [DataW-1:0] size,
                                       input logic [StepW-1:0] from,
                                       input logic [StepW-1:0] live_end, input logic fin);
    logic [EndW-1:0] row_end;
    logic [EndW-1:0] end_i;
    logic [EndW-1:0] end_j;
    alias_result_t r;
    int unsigned reports;
    row_end = {1'b0, off} + {1'b0, size};
    r = '0;
    r.kind = KindRow;
    r.ra = tbl_rows[RowW-1:0];
    r.ida = id;
    r.oob = (model_capacity != 0) && ({1'b0, row_end} > model_capacity);
    r.mis = (model_align != 0) && ((off % model_align) != 0);
    r.bad = (live_end <= from);
    if (r.oob || r.mis || r.bad) tbl_failed = 1'b1;
    if (row_end > tbl_highest) tbl_highest = row_end;
    expected_results.push_back(r);

    if (tbl_rows < RowCap) begin
      tbl_id[tbl_rows] = id;
      tbl_off[tbl_rows] = off;
      tbl_size[tbl_rows] = size;
      tbl_from[tbl_rows] = from;
      tbl_until[tbl_rows] = live_end;
      tbl_rows++;
    end else begin
      tbl_overflow = 1'b1;
    end

    if (fin) begin
      reports = 0;
      // Pair scan in load order, stopping at the report cap.
      for (int unsigned i = 0; i < tbl_rows && reports < ReportCap; i++) begin
        for (int unsigned j = i + 1; j < tbl_rows && reports < ReportCap; j++) begin
          end_i = {1'b0, tbl_off[i]} + {1'b0, tbl_size[i]};
          end_j = {1'b0, tbl_off[j]} + {1'b0, tbl_size[j]};
          if (tbl_from[i] < tbl_until[j] && tbl_from[j] < tbl_until[i] &&
              {1'b0, tbl_off[i]} < end_j && {1'b0, tbl_off[j]} < end_i) begin
            r = '0;
            r.kind = KindPair;
            r.ra = i[RowW-1:0];
            r.rb = j[RowW-1:0];
            r.ida = tbl_id[i];
            r.idb = tbl_id[j];
            expected_results.push_back(r);
            reports++;
            tbl_failed = 1'b1;
          end
        end
      end
      r = '0;
      r.kind = KindSummary;
      r.cnt = reports[5:0];
      r.used = tbl_highest;
      r.verdict = tbl_overflow ? VerdictOverflow : (tbl_failed ? VerdictFail : VerdictPass);
      expected_results.push_back(r);
      tbl_rows = 0;
      tbl_failed = 1'b0;
      tbl_overflow = 1'b0;
      tbl_highest = '0;
    end
    expected_results[expected_results.size() - 1].last = 1'b1;
  endtask

  // Send one row; returns once the transfer has happened.
  task automatic send_row(input logic [DataW-1:0] id, input logic [DataW-1:0] off,
                          input logic [DataW-1:0] size, input logic [StepW-1:0] from,
                          input logic [StepW-1:0] live_end, input logic fin);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    buffer_id_i <= id;
    base_offset_i <= off;
    byte_size_i <= size;
    live_from_i <= from;
    live_until_i <= live_end;
    final_row_i <= fin;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_alias_results(id, off, size, from, live_end, fin);
    rows_sent++;
  endtask

  // Stop sending and wait until every predicted result has been seen.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_register(input logic idx, input logic [CfgW-1:0] value);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegPoolCapacity) model_capacity = value;
    else model_align = value[AlignW-1:0];
  endtask

  // Receiver: random stall bursts and the result check.
  int unsigned stall_left;
  always @(posedge clk_i or negedge rst_ni) begin
    alias_result_t got;
    alias_result_t exp;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got = {result_kind_o, row_a_o, row_b_o, id_a_o, id_b_o, out_of_bounds_o,
               misaligned_o, bad_lifetime_o, conflict_count_o, pool_used_o, verdict_o,
               last_o};
        results_seen++;
        if (got.kind == KindPair) pairs_seen++;
        if (got.kind == KindSummary) summaries_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d", got.kind));
        end else begin
          exp = expected_results.pop_front();
          check_field("result_kind", 64'(got.kind), 64'(exp.kind));
          check_field("row_a", 64'(got.ra), 64'(exp.ra));
          check_field("row_b", 64'(got.rb), 64'(exp.rb));
          check_field("id_a", 64'(got.ida), 64'(exp.ida));
          check_field("id_b", 64'(got.idb), 64'(exp.idb));
          check_field("out_of_bounds", 64'(got.oob), 64'(exp.oob));
          check_field("misaligned", 64'(got.mis), 64'(exp.mis));
          check_field("bad_lifetime", 64'(got.bad), 64'(exp.bad));
          check_field("conflict_count", 64'(got.cnt), 64'(exp.cnt));
          check_field("pool_used", 64'(got.used), 64'(exp.used));
          check_field("verdict", 64'(got.verdict), 64'(exp.verdict));
          check_field("last", 64'(got.last), 64'(exp.last));
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall_i <= (stall_left > 1);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(1, 11);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Directed tables: field extremes, every flag, zero alignment, every register.
  task automatic test_directed();
    // Reset settings: capacity check off, alignment 128.
    send_row(32'h0, 32'h0, 32'd256, 20'd0, 20'd10, 1'b0);
    send_row(32'h1, 32'd128, 32'd128, 20'd5, 20'd20, 1'b0);
    send_row(32'h2, 32'd64, 32'd0, 20'd0, 20'd10, 1'b0);
    send_row(32'h3, 32'd0, 32'd0, 20'd7, 20'd7, 1'b0);
    send_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'hFFFFF, 20'h0, 1'b1);
    // A clean single row passes.
    send_row(32'hA5A5_5A5A, 32'd512, 32'd64, 20'd0, 20'hFFFFF, 1'b1);
    // Capacity of 2^33, no alignment constraint.
    write_register(RegPoolCapacity, 34'h2_0000_0000);
    write_register(RegAlignBytes, '0);
    send_row(32'h10, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'd1, 20'd2, 1'b0);
    send_row(32'h11, 32'h1, 32'h3, 20'd0, 20'd3, 1'b1);
    // Tiny capacity.
    write_register(RegPoolCapacity, 34'd1);
    send_row(32'h20, 32'd0, 32'd1, 20'd0, 20'd1, 1'b0);
    send_row(32'h21, 32'd0, 32'd2, 20'd0, 20'd1, 1'b1);
    // All-ones capacity and alignment.
    write_register(RegPoolCapacity, 34'h3_FFFF_FFFF);
    write_register(RegAlignBytes, 34'hFFFF_FFFF);
    send_row(32'h30, 32'hFFFF_FFFF, 32'd16, 20'd0, 20'd4, 1'b0);
    send_row(32'h31, 32'd1, 32'hFFFF_FFFF, 20'd2, 20'd9, 1'b0);
    send_row(32'h32, 32'd0, 32'd0, 20'd0, 20'd4, 1'b1);
    // Alignment of one.
    write_register(RegAlignBytes, 34'd1);
    write_register(RegPoolCapacity, '0);
    send_row(32'h40, 32'h1234_5677, 32'd9, 20'd3, 20'd8, 1'b1);
  endtask

  // Enough mutually overlapping rows to hit the report cap.
  task automatic test_report_cap();
    for (int k = 0; k < 12; k++)
      send_row($urandom, 32'd1024, 32'd64, 20'd0, 20'd100, k == 11);
  endtask

  // Random tables, mostly well-formed with some noise rows.
  task automatic test_random_tables();
    int unsigned budget;
    int unsigned rows;
    logic [DataW-1:0] off;
    logic [DataW-1:0] size;
    logic [StepW-1:0] from;
    logic [StepW-1:0] live_end;
    budget = 0;
    while (budget < 100) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 3))
          0: write_register(RegPoolCapacity, '0);
          1: write_register(RegPoolCapacity, {2'($urandom_range(0, 3)), $urandom});
          default: write_register(RegPoolCapacity, 34'($urandom_range(256, 8192)));
        endcase
        case ($urandom_range(0, 3))
          0: write_register(RegAlignBytes, 34'($urandom));
          1: write_register(RegAlignBytes, 34'($urandom_range(1, 3)));
          default: write_register(RegAlignBytes, 34'd1 << $urandom_range(0, 8));
        endcase
      end
      if (budget > 75) quiet = 1'b1;
      rows = $urandom_range(1, 8);
      for (int unsigned k = 0; k < rows; k++) begin
        if ($urandom_range(0, 4) == 0) begin
          off = $urandom;
          size = $urandom;
          from = 20'($urandom);
          live_end = 20'($urandom);
        end else begin
          off = $urandom_range(0, 15) * ((model_align == 0 || model_align > 256) ? 32'd64
                                          : model_align);
          size = $urandom_range(0, 512);
          from = 20'($urandom_range(0, 20));
          live_end = from + 20'($urandom_range(0, 20));
        end
        send_row($urandom, off, size, from, live_end, k == rows - 1);
      end
      budget += rows;
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = 1'b0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    buffer_id_i = '0;
    base_offset_i = '0;
    byte_size_i = '0;
    live_from_i = '0;
    live_until_i = '0;
    final_row_i = 1'b0;
    quiet = 1'b0;
    model_capacity = '0;
    model_align = AlignReset;
    tbl_rows = 0;
    tbl_failed = 1'b0;
    tbl_overflow = 1'b0;
    tbl_highest = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    drain_results();
    test_report_cap();
    test_random_tables();

    drain_results();
    repeat (60) @(posedge clk_i);
    $display("Covered %0d rows in directed, report-cap and random tables;",
             rows_sent);
    $display("checked %0d results: %0d alias pairs, %0d summaries.", results_seen,
             pairs_seen, summaries_seen);
    if (error_count == 0 && expected_results.size() == 0)
      $display("buffer_lifetime_alias_checker_unit_tb: PASS");
    else
      $display("buffer_lifetime_alias_checker_unit_tb: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
src/blac_pkg.sv
src/blac_mod_unit.sv
src/buffer_lifetime_alias_checker_unit.sv
tb/buffer_lifetime_alias_checker_unit_tb.sv
